// ===== sv/lcpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lcpe_pkg
// Shared types and constants of the LED color pulse encoder.
// ----------------------------------------------------------------------------
package lcpe_pkg;

    localparam int TICK_W   = 15;
    localparam int BYTE_W   = 8;
    localparam int COLOR_W  = 3 * BYTE_W;
    localparam int NUM_BITS = COLOR_W;
    localparam int BIT_IDX_W = 5;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [BIT_IDX_W-1:0] RESET_SYM_IDX = BIT_IDX_W'(NUM_BITS);

    localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_LOW    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RESET_HIGH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW  = 3'd5;

    localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = 15'd3;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST   = 15'd9;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   = 15'd9;
    localparam logic [TICK_W-1:0] ONE_LOW_RST    = 15'd3;
    localparam logic [TICK_W-1:0] RESET_HIGH_RST = 15'd1400;
    localparam logic [TICK_W-1:0] RESET_LOW_RST  = 15'd1400;

    localparam logic [COLOR_W-1:0] SENT_COLOR_RST = 24'hFFFFFF;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] reset_high;
        logic [TICK_W-1:0] reset_low;
    } t_timing;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ===== sv/lcpe_regs.sv =====
// ----------------------------------------------------------------------------
// lcpe_regs
// APB-style register file holding the pulse timing registers.
// ----------------------------------------------------------------------------
module lcpe_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcpe_pkg::ADDR_W-1:0]   paddr,
    input  logic [lcpe_pkg::DATA_W-1:0]   pwdata,
    output logic [lcpe_pkg::DATA_W-1:0]   prdata,
    output lcpe_pkg::t_timing             o_timing
);

    lcpe_pkg::t_timing                 r_timing;
    logic [lcpe_pkg::REG_IDX_W-1:0]    reg_idx;
    logic [lcpe_pkg::TICK_W-1:0]       wr_val;
    logic [lcpe_pkg::TICK_W-1:0]       rd_val;
    logic                              wr_en;

    assign reg_idx = paddr[lcpe_pkg::ADDR_W-1:2];
    assign wr_val  = pwdata[lcpe_pkg::TICK_W-1:0];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.zero_high  <= lcpe_pkg::ZERO_HIGH_RST;
            r_timing.zero_low   <= lcpe_pkg::ZERO_LOW_RST;
            r_timing.one_high   <= lcpe_pkg::ONE_HIGH_RST;
            r_timing.one_low    <= lcpe_pkg::ONE_LOW_RST;
            r_timing.reset_high <= lcpe_pkg::RESET_HIGH_RST;
            r_timing.reset_low  <= lcpe_pkg::RESET_LOW_RST;
        end else if (wr_en) begin
            case (reg_idx)
                lcpe_pkg::REG_ZERO_HIGH:  r_timing.zero_high  <= wr_val;
                lcpe_pkg::REG_ZERO_LOW:   r_timing.zero_low   <= wr_val;
                lcpe_pkg::REG_ONE_HIGH:   r_timing.one_high   <= wr_val;
                lcpe_pkg::REG_ONE_LOW:    r_timing.one_low    <= wr_val;
                lcpe_pkg::REG_RESET_HIGH: r_timing.reset_high <= wr_val;
                lcpe_pkg::REG_RESET_LOW:  r_timing.reset_low  <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lcpe_pkg::REG_ZERO_HIGH:  rd_val = r_timing.zero_high;
            lcpe_pkg::REG_ZERO_LOW:   rd_val = r_timing.zero_low;
            lcpe_pkg::REG_ONE_HIGH:   rd_val = r_timing.one_high;
            lcpe_pkg::REG_ONE_LOW:    rd_val = r_timing.one_low;
            lcpe_pkg::REG_RESET_HIGH: rd_val = r_timing.reset_high;
            lcpe_pkg::REG_RESET_LOW:  rd_val = r_timing.reset_low;
            default:                  rd_val = '0;
        endcase
    end

    assign prdata   = {{(lcpe_pkg::DATA_W - lcpe_pkg::TICK_W){1'b0}}, rd_val};
    assign o_timing = r_timing;

endmodule

// ===== sv/lcpe_fifo.sv =====
// ----------------------------------------------------------------------------
// lcpe_fifo
// Small flop-based queue between the classifying front and the symbol back.
// ----------------------------------------------------------------------------
module lcpe_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic                  i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output lcpe_pkg::t_fifo_stat  o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_wr;
    logic              do_rd;

    assign do_wr = i_wr && (r_count != FULL_CNT);
    assign do_rd = i_rd && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_rptr];
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== sv/lcpe_front.sv =====
// ----------------------------------------------------------------------------
// lcpe_front
// Accepts colors, drops repeats of the last color sent, queues the rest
// in line order green, red, blue.
// ----------------------------------------------------------------------------
module lcpe_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [lcpe_pkg::BYTE_W-1:0]    i_red,
    input  logic [lcpe_pkg::BYTE_W-1:0]    i_green,
    input  logic [lcpe_pkg::BYTE_W-1:0]    i_blue,
    input  lcpe_pkg::t_fifo_stat           i_fifo_stat,
    output logic                           o_fifo_wr,
    output logic [lcpe_pkg::COLOR_W-1:0]   o_fifo_wdata
);

    logic [lcpe_pkg::COLOR_W-1:0] r_sent_color;
    logic                         r_sent_valid;
    logic [lcpe_pkg::COLOR_W-1:0] color;
    logic                         accept;
    logic                         changed;

    assign color   = {i_red, i_green, i_blue};
    assign accept  = i_push && !i_fifo_stat.full;
    assign changed = !r_sent_valid || (color != r_sent_color);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_color <= lcpe_pkg::SENT_COLOR_RST;
            r_sent_valid <= 1'b0;
        end else if (accept && changed) begin
            r_sent_color <= color;
            r_sent_valid <= 1'b1;
        end
    end

    assign o_fifo_wr    = accept && changed;
    assign o_fifo_wdata = {i_green, i_red, i_blue};

endmodule

// ===== sv/lcpe_back.sv =====
// ----------------------------------------------------------------------------
// lcpe_back
// Shifts one pulse symbol per cycle, unless held for a pop, for each queued
// color, then the closing reset symbol, into a one-entry output register.
// ----------------------------------------------------------------------------
module lcpe_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lcpe_pkg::t_timing              i_timing,
    input  lcpe_pkg::t_fifo_stat           i_fifo_stat,
    input  logic [lcpe_pkg::COLOR_W-1:0]   i_fifo_rdata,
    output logic                           o_fifo_rd,
    input  logic                           i_pop,
    output logic                           o_valid,
    output logic [lcpe_pkg::TICK_W-1:0]    o_high_ticks,
    output logic [lcpe_pkg::TICK_W-1:0]    o_low_ticks,
    output logic                           o_is_reset,
    output logic                           o_last_symbol
);

    logic                            r_busy;
    logic [lcpe_pkg::BIT_IDX_W-1:0]  r_bit_idx;
    logic [lcpe_pkg::COLOR_W-1:0]    r_shift;
    logic                            r_out_valid;
    logic [lcpe_pkg::TICK_W-1:0]     r_out_high;
    logic [lcpe_pkg::TICK_W-1:0]     r_out_low;
    logic                            r_out_is_reset;
    logic                            adv;
    logic                            at_reset_sym;
    logic                            load;

    assign adv          = !r_out_valid || i_pop;
    assign at_reset_sym = (r_bit_idx == lcpe_pkg::RESET_SYM_IDX);
    assign load         = adv && (!r_busy || at_reset_sym) && !i_fifo_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_bit_idx   <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_busy;
            if (load) begin
                r_busy    <= 1'b1;
                r_bit_idx <= '0;
            end else if (r_busy && at_reset_sym) begin
                r_busy    <= 1'b0;
                r_bit_idx <= '0;
            end else if (r_busy) begin
                r_bit_idx <= r_bit_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_shift <= i_fifo_rdata;
        end else if (adv && r_busy) begin
            r_shift <= {r_shift[lcpe_pkg::COLOR_W-2:0], 1'b0};
        end
        if (adv && r_busy) begin
            r_out_is_reset <= at_reset_sym;
            if (at_reset_sym) begin
                r_out_high <= i_timing.reset_high;
                r_out_low  <= i_timing.reset_low;
            end else if (r_shift[lcpe_pkg::COLOR_W-1]) begin
                r_out_high <= i_timing.one_high;
                r_out_low  <= i_timing.one_low;
            end else begin
                r_out_high <= i_timing.zero_high;
                r_out_low  <= i_timing.zero_low;
            end
        end
    end

    assign o_fifo_rd     = load;
    assign o_valid       = r_out_valid;
    assign o_high_ticks  = r_out_high;
    assign o_low_ticks   = r_out_low;
    assign o_is_reset    = r_out_is_reset;
    assign o_last_symbol = r_out_is_reset;

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_idx <= lcpe_pkg::RESET_SYM_IDX)
        else $error("bit index out of range");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_bit_idx == '0)
        else $error("bit index nonzero while idle");

    a_reset_sym_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_busy && at_reset_sym |=> r_out_valid && r_out_is_reset)
        else $error("closing reset symbol not presented");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> !i_fifo_stat.empty && (!r_busy || at_reset_sym))
        else $error("color loaded mid frame");
`endif

endmodule

// ===== sv/led_color_pulse_encoder.sv =====
// ----------------------------------------------------------------------------
// led_color_pulse_encoder
// Turns colors into GRB pulse symbols, skipping repeats of the last color.
// ----------------------------------------------------------------------------
// Path: a new color goes through the queue and the symbol shifter into the
// output register. Throughput: one symbol per cycle while the output is empty
// or popped; a new color yields a symbol per bit and a reset symbol, a repeat none.
// Reset (synchronous): timing registers return to defaults, queues empty,
// no color counts as sent, so the first color is always sent.
module led_color_pulse_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lcpe_pkg::ADDR_W-1:0]    paddr,
    input  logic [lcpe_pkg::DATA_W-1:0]    pwdata,
    output logic [lcpe_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           push,
    output logic                           full,
    input  logic [lcpe_pkg::BYTE_W-1:0]    i_red,
    input  logic [lcpe_pkg::BYTE_W-1:0]    i_green,
    input  logic [lcpe_pkg::BYTE_W-1:0]    i_blue,
    output logic                           empty,
    input  logic                           pop,
    output logic [lcpe_pkg::TICK_W-1:0]    o_high_ticks,
    output logic [lcpe_pkg::TICK_W-1:0]    o_low_ticks,
    output logic                           o_is_reset,
    output logic                           o_last_symbol
);

    lcpe_pkg::t_timing              timing;
    lcpe_pkg::t_fifo_stat           fifo_stat;
    logic                           fifo_wr;
    logic                           fifo_rd;
    logic [lcpe_pkg::COLOR_W-1:0]   fifo_wdata;
    logic [lcpe_pkg::COLOR_W-1:0]   fifo_rdata;
    logic                           out_valid;

    lcpe_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .o_timing (timing)
    );

    lcpe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_fifo_stat  (fifo_stat),
        .o_fifo_wr    (fifo_wr),
        .o_fifo_wdata (fifo_wdata)
    );

    lcpe_fifo #(
        .WIDTH (lcpe_pkg::COLOR_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fifo_wr),
        .i_wdata (fifo_wdata),
        .i_rd    (fifo_rd),
        .o_rdata (fifo_rdata),
        .o_stat  (fifo_stat)
    );

    lcpe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_timing      (timing),
        .i_fifo_stat   (fifo_stat),
        .i_fifo_rdata  (fifo_rdata),
        .o_fifo_rd     (fifo_rd),
        .i_pop         (pop),
        .o_valid       (out_valid),
        .o_high_ticks  (o_high_ticks),
        .o_low_ticks   (o_low_ticks),
        .o_is_reset    (o_is_reset),
        .o_last_symbol (o_last_symbol)
    );

    assign pready = 1'b1;
    assign full   = fifo_stat.full;
    assign empty  = !out_valid;

endmodule

// ===== tb/lcpe_pulse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcpe_pulse_checker
// Watches the color input, the symbol output and the register port of the
// LED color pulse encoder. It keeps its own copy of the timing registers and
// of the last color sent, and expands every accepted color into the symbols
// the block should produce. Each popped symbol is compared field by field
// with the oldest expected symbol. It counts failures and reports how many
// symbols are still owed.
// ----------------------------------------------------------------------------
module lcpe_pulse_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [lcpe_pkg::ADDR_W-1:0]   paddr,
    input  logic [lcpe_pkg::DATA_W-1:0]   pwdata,
    input  logic                          push,
    input  logic                          full,
    input  logic [lcpe_pkg::BYTE_W-1:0]   i_red,
    input  logic [lcpe_pkg::BYTE_W-1:0]   i_green,
    input  logic [lcpe_pkg::BYTE_W-1:0]   i_blue,
    input  logic                          pop,
    input  logic                          empty,
    input  logic [lcpe_pkg::TICK_W-1:0]   i_high_ticks,
    input  logic [lcpe_pkg::TICK_W-1:0]   i_low_ticks,
    input  logic                          i_is_reset,
    input  logic                          i_last_symbol,
    output int                            o_errors,
    output int                            o_pending
);

    typedef struct packed {
        logic [lcpe_pkg::TICK_W-1:0] high_ticks;
        logic [lcpe_pkg::TICK_W-1:0] low_ticks;
        logic                        is_reset;
        logic                        last_symbol;
    } t_pulse_sym;

    lcpe_pkg::t_timing                timing;
    logic [lcpe_pkg::COLOR_W-1:0]     sent_color;
    logic                             sent_valid;
    t_pulse_sym                       owed_symbols[$];
    int                               err_count;

    function automatic void expand_color(input logic [lcpe_pkg::BYTE_W-1:0] red,
                                         input logic [lcpe_pkg::BYTE_W-1:0] green,
                                         input logic [lcpe_pkg::BYTE_W-1:0] blue);
        logic [lcpe_pkg::COLOR_W-1:0] color;
        logic [lcpe_pkg::COLOR_W-1:0] line_bits;
        t_pulse_sym                   sym;
        int                           i;
        color     = {red, green, blue};
        line_bits = {green, red, blue};
        if (sent_valid && color == sent_color) begin
            return;
        end
        for (i = lcpe_pkg::COLOR_W - 1; i >= 0; i--) begin
            if (line_bits[i]) begin
                sym.high_ticks = timing.one_high;
                sym.low_ticks  = timing.one_low;
            end else begin
                sym.high_ticks = timing.zero_high;
                sym.low_ticks  = timing.zero_low;
            end
            sym.is_reset    = 1'b0;
            sym.last_symbol = 1'b0;
            owed_symbols.push_back(sym);
        end
        sym.high_ticks  = timing.reset_high;
        sym.low_ticks   = timing.reset_low;
        sym.is_reset    = 1'b1;
        sym.last_symbol = 1'b1;
        owed_symbols.push_back(sym);
        sent_color = color;
        sent_valid = 1'b1;
    endfunction

    function automatic void check_field(input string name, input int exp_val,
                                        input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pulse_sym                  exp_sym;
        logic [lcpe_pkg::TICK_W-1:0] wr_val;
        wr_val = pwdata[lcpe_pkg::TICK_W-1:0];
        if (!i_rst_n) begin
            timing.zero_high  = lcpe_pkg::ZERO_HIGH_RST;
            timing.zero_low   = lcpe_pkg::ZERO_LOW_RST;
            timing.one_high   = lcpe_pkg::ONE_HIGH_RST;
            timing.one_low    = lcpe_pkg::ONE_LOW_RST;
            timing.reset_high = lcpe_pkg::RESET_HIGH_RST;
            timing.reset_low  = lcpe_pkg::RESET_LOW_RST;
            sent_color        = lcpe_pkg::SENT_COLOR_RST;
            sent_valid        = 1'b0;
            owed_symbols.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[lcpe_pkg::ADDR_W-1:2])
                    lcpe_pkg::REG_ZERO_HIGH:  timing.zero_high  = wr_val;
                    lcpe_pkg::REG_ZERO_LOW:   timing.zero_low   = wr_val;
                    lcpe_pkg::REG_ONE_HIGH:   timing.one_high   = wr_val;
                    lcpe_pkg::REG_ONE_LOW:    timing.one_low    = wr_val;
                    lcpe_pkg::REG_RESET_HIGH: timing.reset_high = wr_val;
                    lcpe_pkg::REG_RESET_LOW:  timing.reset_low  = wr_val;
                    default: ;
                endcase
            end
            if (push && !full) begin
                expand_color(i_red, i_green, i_blue);
            end
            if (pop && !empty) begin
                if (owed_symbols.size() == 0) begin
                    $error("unexpected symbol: high_ticks %0d low_ticks %0d is_reset %0b",
                           i_high_ticks, i_low_ticks, i_is_reset);
                    err_count++;
                end else begin
                    exp_sym = owed_symbols.pop_front();
                    check_field("high_ticks", exp_sym.high_ticks, i_high_ticks);
                    check_field("low_ticks", exp_sym.low_ticks, i_low_ticks);
                    check_field("is_reset", exp_sym.is_reset, i_is_reset);
                    check_field("last_symbol", exp_sym.last_symbol, i_last_symbol);
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= owed_symbols.size();
    end

endmodule

// ===== tb/tb_led_color_pulse_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_color_pulse_encoder
// Drives colors and timing register writes into the LED color pulse encoder
// and pops its symbols with random gaps on both sides. A directed set covers
// the first color after reset, repeats, extremes and single-bit changes;
// random phases run under zero, maximum, masked-wide and random timings, one
// of them with a long output hold so the input stalls. Checking is done by
// the checker beside the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_led_color_pulse_encoder;

    localparam logic [lcpe_pkg::REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [lcpe_pkg::REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                          i_clk    = 1'b0;
    logic                          i_rst_n  = 1'b0;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [lcpe_pkg::ADDR_W-1:0]   paddr    = '0;
    logic [lcpe_pkg::DATA_W-1:0]   pwdata   = '0;
    logic [lcpe_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          push     = 1'b0;
    logic                          full;
    logic [lcpe_pkg::BYTE_W-1:0]   i_red    = '0;
    logic [lcpe_pkg::BYTE_W-1:0]   i_green  = '0;
    logic [lcpe_pkg::BYTE_W-1:0]   i_blue   = '0;
    logic                          empty;
    logic                          pop      = 1'b0;
    logic [lcpe_pkg::TICK_W-1:0]   o_high_ticks;
    logic [lcpe_pkg::TICK_W-1:0]   o_low_ticks;
    logic                          o_is_reset;
    logic                          o_last_symbol;

    int                            errors;
    int                            pending;
    int                            idle_cycles = 0;
    logic                          hold_req    = 1'b0;
    logic                          no_idle     = 1'b0;
    logic [lcpe_pkg::COLOR_W-1:0]  prev_color  = lcpe_pkg::SENT_COLOR_RST;

    always #5 i_clk = ~i_clk;

    led_color_pulse_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .empty         (empty),
        .pop           (pop),
        .o_high_ticks  (o_high_ticks),
        .o_low_ticks   (o_low_ticks),
        .o_is_reset    (o_is_reset),
        .o_last_symbol (o_last_symbol)
    );

    lcpe_pulse_checker i_pulse_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .push          (push),
        .full          (full),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .pop           (pop),
        .empty         (empty),
        .i_high_ticks  (o_high_ticks),
        .i_low_ticks   (o_low_ticks),
        .i_is_reset    (o_is_reset),
        .i_last_symbol (o_last_symbol),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL led_color_pulse_encoder");
            $finish;
        end
    end

    task automatic write_reg(input logic [lcpe_pkg::REG_IDX_W-1:0] idx,
                             input logic [lcpe_pkg::DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_timing(input logic [lcpe_pkg::DATA_W-1:0] zero_high,
                                  input logic [lcpe_pkg::DATA_W-1:0] zero_low,
                                  input logic [lcpe_pkg::DATA_W-1:0] one_high,
                                  input logic [lcpe_pkg::DATA_W-1:0] one_low,
                                  input logic [lcpe_pkg::DATA_W-1:0] reset_high,
                                  input logic [lcpe_pkg::DATA_W-1:0] reset_low);
        write_reg(lcpe_pkg::REG_ZERO_HIGH, zero_high);
        write_reg(lcpe_pkg::REG_ZERO_LOW, zero_low);
        write_reg(lcpe_pkg::REG_ONE_HIGH, one_high);
        write_reg(lcpe_pkg::REG_ONE_LOW, one_low);
        write_reg(lcpe_pkg::REG_RESET_HIGH, reset_high);
        write_reg(lcpe_pkg::REG_RESET_LOW, reset_low);
    endtask

    task automatic send_color(input logic [lcpe_pkg::COLOR_W-1:0] color);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    <= 1'b1;
        i_red   <= color[23:16];
        i_green <= color[15:8];
        i_blue  <= color[7:0];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        prev_color = color;
    endtask

    task automatic wait_drained(input int extra);
        @(negedge i_clk);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    function automatic logic [lcpe_pkg::COLOR_W-1:0] pick_color(
        input logic [lcpe_pkg::COLOR_W-1:0] last);
        logic [lcpe_pkg::COLOR_W-1:0] color;
        int roll;
        roll  = $urandom_range(0, 99);
        color = last;
        if (roll < 25) begin
            color = last;
        end else if (roll < 40) begin
            color = color ^ (lcpe_pkg::COLOR_W'(1) << $urandom_range(0, lcpe_pkg::COLOR_W - 1));
        end else if (roll < 50) begin
            color = {{lcpe_pkg::BYTE_W{$urandom_range(0, 1) == 1}},
                     {lcpe_pkg::BYTE_W{$urandom_range(0, 1) == 1}},
                     {lcpe_pkg::BYTE_W{$urandom_range(0, 1) == 1}}};
        end else begin
            color = lcpe_pkg::COLOR_W'($urandom());
        end
        return color;
    endfunction

    task automatic run_random(input int fresh_target);
        logic [lcpe_pkg::COLOR_W-1:0] color;
        int fresh;
        fresh = 0;
        while (fresh < fresh_target) begin
            color = pick_color(prev_color);
            if (color != prev_color) begin
                fresh++;
            end
            send_color(color);
        end
    endtask

    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 7);
            @(negedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    initial begin : color_source
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_color(24'hFFFFFF);
        send_color(24'hFFFFFF);
        send_color(24'h000000);
        send_color(24'h000000);
        send_color(24'hFF0000);
        send_color(24'h00FF00);
        send_color(24'h0000FF);
        send_color(24'hAA55AA);
        send_color(24'h55AA55);
        send_color(24'h800180);
        send_color(24'h018001);
        send_color(24'h010101);
        send_color(24'h808080);
        send_color(24'h7F7F7F);
        send_color(24'hFFFFFF);
        send_color(24'hFFFFFF);
        send_color(24'h123456);
        send_color(24'h123457);
        send_color(24'h123456);
        send_color(24'hFEFFFF);
        wait_drained(SETTLE_CYCLES);

        program_timing('0, '0, '0, '0, '0, '0);
        hold_req = 1'b1;
        run_random(50);
        wait_drained(SETTLE_CYCLES);

        program_timing('1, '1, '1, '1, '1, '1);
        write_reg(REG_UNUSED_LO, $urandom());
        write_reg(REG_UNUSED_HI, $urandom());
        run_random(90);
        wait_drained(SETTLE_CYCLES);

        program_timing($urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom());
        run_random(90);
        wait_drained(SETTLE_CYCLES);

        program_timing({17'($urandom_range(0, 131071)), 15'($urandom_range(0, 31))},
                       {17'($urandom_range(0, 131071)), 15'($urandom_range(0, 31))},
                       {17'($urandom_range(0, 131071)), 15'($urandom_range(0, 31))},
                       {17'($urandom_range(0, 131071)), 15'($urandom_range(0, 31))},
                       {17'($urandom_range(0, 131071)), 15'($urandom_range(0, 31))},
                       {17'($urandom_range(0, 131071)), 15'($urandom_range(0, 31))});
        write_reg(REG_UNUSED_LO, '1);
        no_idle = 1'b1;
        run_random(50);
        no_idle = 1'b0;
        run_random(30);
        wait_drained(END_CYCLES);

        if (errors == 0) begin
            $display("PASS led_color_pulse_encoder");
        end else begin
            $display("FAIL led_color_pulse_encoder");
        end
        $finish;
    end

endmodule
